[rtl/bma_pkg.sv]
// Shared types and constants of the buddy memory allocator.
// No dependencies.
package bma_pkg;

    localparam int DEF_TOTAL_UNITS = 1024;
    localparam int DEF_OWNER_COUNT = 1024;
    localparam int REQ_W           = 11;
    localparam int OWNER_W         = 10;
    localparam int STATUS_W        = 2;
    localparam int CEIL_W          = REQ_W + 1;

    typedef enum logic [1:0] {
        NS_ABSENT = 2'd0,
        NS_FREE   = 2'd1,
        NS_USED   = 2'd2,
        NS_SPLIT  = 2'd3
    } t_node_st;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK       = 2'd0,
        RES_NOSPACE  = 2'd1,
        RES_NOTFOUND = 2'd2
    } t_result;

    typedef enum logic [2:0] {
        NAV_HOLD = 3'd0,
        NAV_ROOT = 3'd1,
        NAV_DESC = 3'd2,
        NAV_SIB  = 3'd3,
        NAV_UP   = 3'd4,
        NAV_TOP  = 3'd5
    } t_nav;

    typedef enum logic [1:0] {
        WS_NODE  = 2'd0,
        WS_PREV  = 2'd1,
        WS_LEFT  = 2'd2,
        WS_RIGHT = 2'd3
    } t_wsel;

    typedef struct packed {
        logic     load;
        logic     clr;
        t_nav     nav;
        logic     st_we;
        t_node_st st_wd;
        t_wsel    wsel;
        logic     own_we;
        logic     mark_top;
    } t_dp_cmd;

    typedef struct packed {
        t_node_st st;
        logic     size_eq_c;
        logic     size_lt_r;
        logic     can_split;
        logic     own_match;
        logic     is_root;
        logic     is_left;
        logic     kind;
        logic     who_ok;
        logic     clr_last;
    } t_dp_stat;

endpackage

[rtl/bma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bma_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2047
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

[rtl/bma_ctrl.sv]
// Allocator controller: sequences searches, splits, frees and merges.
// Depends on bma_pkg; drives bma_dp through t_dp_cmd.
module bma_ctrl
    import bma_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output t_dp_cmd             o_cmd,
    input  t_dp_stat            i_stat
);
    typedef enum logic [12:0] {
        S_CLR  = 13'b0000000000001,
        S_IDLE = 13'b0000000000010,
        S_PRE  = 13'b0000000000100,
        S_RD   = 13'b0000000001000,
        S_EV   = 13'b0000000010000,
        S_ADV  = 13'b0000000100000,
        S_SPL1 = 13'b0000001000000,
        S_SPL2 = 13'b0000010000000,
        S_MRET = 13'b0000100000000,
        S_MCHK = 13'b0001000000000,
        S_MWL  = 13'b0010000000000,
        S_MWP  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    typedef enum logic [2:0] {
        M_EXACT, M_PLACE, M_OWNER, M_MERGE, M_MERGE_L, M_MERGE_R
    } t_mode;

    t_state  r_state, n_state;
    t_mode   r_mode, n_mode;
    logic    r_fresh, n_fresh;
    logic    r_lfree, n_lfree;
    t_result r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_mode  <= M_EXACT;
            r_fresh <= 1'b0;
            r_lfree <= 1'b0;
            r_res   <= RES_OK;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_fresh <= n_fresh;
            r_lfree <= n_lfree;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_fresh = r_fresh;
        n_lfree = r_lfree;
        n_res   = r_res;
        o_cmd   = '{load: 1'b0, clr: 1'b0, nav: NAV_HOLD, st_we: 1'b0, st_wd: NS_ABSENT,
                    wsel: WS_NODE, own_we: 1'b0, mark_top: 1'b0};
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_fresh    = 1'b0;
                    n_state    = S_PRE;
                end
            end
            S_PRE: begin
                if (!i_stat.who_ok) begin
                    n_res   = i_stat.kind ? RES_NOTFOUND : RES_NOSPACE;
                    n_state = S_DONE;
                end else begin
                    n_mode  = i_stat.kind ? M_OWNER : M_EXACT;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                case (r_mode)
                    M_EXACT: begin
                        if (i_stat.st == NS_FREE && i_stat.size_eq_c) begin
                            o_cmd.st_we  = 1'b1;
                            o_cmd.st_wd  = NS_USED;
                            o_cmd.own_we = 1'b1;
                            n_res        = RES_OK;
                            n_state      = S_DONE;
                        end else if (i_stat.st == NS_SPLIT) begin
                            o_cmd.nav = NAV_DESC;
                            n_state   = S_RD;
                        end else begin
                            n_state = S_ADV;
                        end
                    end
                    M_PLACE: begin
                        if (i_stat.st == NS_SPLIT && !i_stat.size_lt_r) begin
                            o_cmd.nav = NAV_DESC;
                            n_state   = S_RD;
                        end else if (i_stat.st == NS_FREE && !i_stat.size_lt_r
                                     && i_stat.size_eq_c) begin
                            o_cmd.st_we  = 1'b1;
                            o_cmd.st_wd  = NS_USED;
                            o_cmd.own_we = 1'b1;
                            n_res        = RES_OK;
                            n_state      = S_DONE;
                        end else if (i_stat.st == NS_FREE && !i_stat.size_lt_r
                                     && i_stat.can_split) begin
                            o_cmd.st_we    = 1'b1;
                            o_cmd.st_wd    = NS_SPLIT;
                            o_cmd.mark_top = !r_fresh;
                            n_state        = S_SPL1;
                        end else begin
                            // a failed fresh split abandons its whole subtree
                            if (r_fresh) begin
                                o_cmd.nav = NAV_TOP;
                            end
                            n_fresh = 1'b0;
                            n_state = S_ADV;
                        end
                    end
                    M_OWNER: begin
                        if (i_stat.st == NS_USED && i_stat.own_match) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st_wd = NS_FREE;
                            o_cmd.nav   = NAV_ROOT;
                            n_mode      = M_MERGE;
                            n_state     = S_RD;
                        end else if (i_stat.st == NS_SPLIT) begin
                            o_cmd.nav = NAV_DESC;
                            n_state   = S_RD;
                        end else begin
                            n_state = S_ADV;
                        end
                    end
                    M_MERGE: begin
                        if (i_stat.st == NS_SPLIT) begin
                            o_cmd.nav = NAV_DESC;
                            n_state   = S_RD;
                        end else begin
                            n_state = S_MRET;
                        end
                    end
                    M_MERGE_L: begin
                        n_lfree   = (i_stat.st == NS_FREE);
                        o_cmd.nav = NAV_SIB;
                        n_mode    = M_MERGE_R;
                        n_state   = S_RD;
                    end
                    M_MERGE_R: begin
                        n_mode = M_MERGE;
                        if (r_lfree && i_stat.st == NS_FREE) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st_wd = NS_ABSENT;
                            n_state     = S_MWL;
                        end else begin
                            o_cmd.nav = NAV_UP;
                            n_state   = S_MRET;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ADV: begin
                if (i_stat.is_root) begin
                    case (r_mode)
                        M_EXACT: begin
                            o_cmd.nav = NAV_ROOT;
                            n_mode    = M_PLACE;
                            n_fresh   = 1'b0;
                            n_state   = S_RD;
                        end
                        M_PLACE: begin
                            n_res   = RES_NOSPACE;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_res   = RES_NOTFOUND;
                            n_state = S_DONE;
                        end
                    endcase
                end else if (i_stat.is_left) begin
                    o_cmd.nav = NAV_SIB;
                    n_state   = S_RD;
                end else begin
                    o_cmd.nav = NAV_UP;
                end
            end
            S_SPL1: begin
                o_cmd.st_we = 1'b1;
                o_cmd.st_wd = NS_FREE;
                o_cmd.wsel  = WS_LEFT;
                n_state     = S_SPL2;
            end
            S_SPL2: begin
                o_cmd.st_we = 1'b1;
                o_cmd.st_wd = NS_FREE;
                o_cmd.wsel  = WS_RIGHT;
                o_cmd.nav   = NAV_DESC;
                n_fresh     = 1'b1;
                n_state     = S_RD;
            end
            S_MRET: begin
                if (i_stat.is_root) begin
                    n_res   = RES_OK;
                    n_state = S_DONE;
                end else if (i_stat.is_left) begin
                    o_cmd.nav = NAV_SIB;
                    n_mode    = M_MERGE;
                    n_state   = S_RD;
                end else begin
                    o_cmd.nav = NAV_UP;
                    n_state   = S_MCHK;
                end
            end
            S_MCHK: begin
                o_cmd.nav = NAV_DESC;
                n_mode    = M_MERGE_L;
                n_state   = S_RD;
            end
            S_MWL: begin
                o_cmd.st_we = 1'b1;
                o_cmd.st_wd = NS_ABSENT;
                o_cmd.wsel  = WS_PREV;
                o_cmd.nav   = NAV_UP;
                n_state     = S_MWP;
            end
            S_MWP: begin
                o_cmd.st_we = 1'b1;
                o_cmd.st_wd = NS_FREE;
                n_state     = S_MRET;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_status = r_res;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("result strobe not single or not followed by idle");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == RES_OK || o_status == RES_NOSPACE
                    || o_status == RES_NOTFOUND))
        else $error("bad status code");
    a_fresh_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh |-> r_mode == M_PLACE)
        else $error("fresh split flag outside placement");
endmodule

[rtl/bma_dp.sv]
// Allocator datapath: tree cursor, request registers and node memories.
// Depends on bma_pkg and bma_ram; steered by bma_ctrl through t_dp_cmd.
module bma_dp
    import bma_pkg::*;
#(
    parameter int TOTAL_UNITS = DEF_TOTAL_UNITS,
    parameter int OWNER_COUNT = DEF_OWNER_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_kind,
    input  logic [REQ_W-1:0]   i_request_size,
    input  logic [OWNER_W-1:0] i_owner_id,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat
);
    localparam int NODE_COUNT = 2 * TOTAL_UNITS - 1;
    localparam int IW = $clog2(NODE_COUNT);
    localparam int NW = IW + 1;
    localparam int DW = $clog2($clog2(TOTAL_UNITS) + 2);
    localparam int SW = $clog2(TOTAL_UNITS + 1);
    localparam int KW = (SW > CEIL_W) ? SW : CEIL_W;
    localparam logic [SW-1:0]      TOT     = SW'(TOTAL_UNITS);
    localparam logic [NW:0]        NC_WIDE = (NW+1)'(NODE_COUNT);
    localparam logic [IW-1:0]      NC_LAST = IW'(NODE_COUNT - 1);
    localparam logic               WHO_ALL = (OWNER_COUNT >= (1 << OWNER_W));
    localparam logic [OWNER_W-1:0] OC_LIM  = OWNER_W'(OWNER_COUNT);

    logic [NW-1:0]      r_node, n_node, r_top;
    logic [DW-1:0]      r_depth, n_depth, r_topd;
    logic               r_kind;
    logic [REQ_W-1:0]   r_req;
    logic [CEIL_W-1:0]  r_c, n_c;
    logic [OWNER_W-1:0] r_who;
    logic [IW-1:0]      r_clr;

    logic [NW:0]        left_w, right_w, prev_w;
    logic [IW-1:0]      st_waddr;
    logic [1:0]         st_wdata, st_q;
    logic [OWNER_W-1:0] own_q;
    logic [SW-1:0]      size;
    logic               in_range;

    assign left_w  = {r_node, 1'b0} + (NW+1)'(1);
    assign right_w = {r_node, 1'b0} + (NW+1)'(2);
    assign prev_w  = {1'b0, r_node} - (NW+1)'(1);

    always_comb begin
        n_c = CEIL_W'(1) << (CEIL_W - 1);
        for (int i = CEIL_W - 1; i >= 0; i--) begin
            if ((CEIL_W'(1) << i) >= {1'b0, i_request_size}) begin
                n_c = CEIL_W'(1) << i;
            end
        end
    end

    always_comb begin
        n_node  = r_node;
        n_depth = r_depth;
        case (i_cmd.nav)
            NAV_ROOT: begin
                n_node  = '0;
                n_depth = '0;
            end
            NAV_DESC: begin
                n_node  = left_w[NW-1:0];
                n_depth = r_depth + DW'(1);
            end
            NAV_SIB: begin
                n_node = r_node + NW'(1);
            end
            NAV_UP: begin
                n_node  = prev_w[NW:1];
                n_depth = r_depth - DW'(1);
            end
            NAV_TOP: begin
                n_node  = r_top;
                n_depth = r_topd;
            end
            default: begin
                n_node  = r_node;
                n_depth = r_depth;
            end
        endcase
        if (i_cmd.load) begin
            n_node  = '0;
            n_depth = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_depth <= n_depth;
        if (i_cmd.mark_top) begin
            r_top  <= r_node;
            r_topd <= r_depth;
        end
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_req  <= i_request_size;
            r_c    <= n_c;
            r_who  <= i_owner_id;
        end
    end

    always_comb begin
        case (i_cmd.wsel)
            WS_PREV:  st_waddr = prev_w[IW-1:0];
            WS_LEFT:  st_waddr = left_w[IW-1:0];
            WS_RIGHT: st_waddr = right_w[IW-1:0];
            default:  st_waddr = r_node[IW-1:0];
        endcase
        st_wdata = i_cmd.st_wd;
        if (i_cmd.clr) begin
            st_waddr = r_clr;
            st_wdata = (r_clr == '0) ? NS_FREE : NS_ABSENT;
        end
    end

    bma_ram #(.WIDTH(2), .DEPTH(NODE_COUNT)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.st_we || i_cmd.clr),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (r_node[IW-1:0]),
        .o_rdata (st_q)
    );

    bma_ram #(.WIDTH(OWNER_W), .DEPTH(NODE_COUNT)) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.own_we),
        .i_waddr (r_node[IW-1:0]),
        .i_wdata (r_who),
        .i_raddr (r_node[IW-1:0]),
        .o_rdata (own_q)
    );

    assign in_range = ({1'b0, r_node} < NC_WIDE);
    assign size     = TOT >> r_depth;

    always_comb begin
        o_stat.st        = in_range ? t_node_st'(st_q) : NS_ABSENT;
        o_stat.size_eq_c = (KW'(size) == KW'(r_c));
        o_stat.size_lt_r = (KW'(size) < KW'(r_req));
        o_stat.can_split = (KW'(size) > KW'(r_req)) && (size > SW'(1)) && (right_w < NC_WIDE);
        o_stat.own_match = (own_q == r_who);
        o_stat.is_root   = (r_node == '0);
        o_stat.is_left   = r_node[0];
        o_stat.kind      = r_kind;
        o_stat.who_ok    = WHO_ALL || (r_who < OC_LIM);
        o_stat.clr_last  = (r_clr == NC_LAST);
    end
endmodule

[rtl/buddy_memory_allocator.sv]
// Buddy memory allocator top level: controller plus datapath.
// Depends on bma_pkg, bma_ctrl, bma_dp (which holds the bma_ram node stores).
//
//  channel   handshake            ports
//  command   start & !busy        i_kind, i_request_size, i_owner_id
//  result    o_done (1 cycle)     o_status
//
// Fixed cost per transfer: accept, owner check and result cycles.
// Each node visit is a memory read then a decision, plus an advance step for a move
// to a sibling and one per level climbed; a split adds writes of both children.
// Allocate: exact-size pass, then placement pass. Free: owner search, then a full
// post-order merge sweep over the tree.
// After reset a clearing pass writes all 2*TOTAL_UNITS-1 nodes with busy high.
// The result strobe cannot be stalled.
module buddy_memory_allocator
    import bma_pkg::*;
#(
    parameter int TOTAL_UNITS = DEF_TOTAL_UNITS,
    parameter int OWNER_COUNT = DEF_OWNER_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_kind,
    input  logic [REQ_W-1:0]    i_request_size,
    input  logic [OWNER_W-1:0]  i_owner_id,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    bma_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_done   (o_done),
        .o_status (o_status),
        .o_cmd    (cmd),
        .i_stat   (stat)
    );

    bma_dp #(.TOTAL_UNITS(TOTAL_UNITS), .OWNER_COUNT(OWNER_COUNT)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_kind),
        .i_request_size (i_request_size),
        .i_owner_id     (i_owner_id),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );
endmodule
